/* rtl/smsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample mean and standard deviation package
// Sizes, derived widths and status codes shared by the block and its units.
// ----------------------------------------------------------------------------
package smsd_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int SAMPLE_W    = 16;
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
   localparam int ADDR_W      = $clog2(MAX_SAMPLES);
   localparam int SUM_W       = SAMPLE_W + ADDR_W;
   localparam int SQ_W        = 2 * SAMPLE_W + ADDR_W;
   localparam int ROOT_W      = (SQ_W + 1) / 2;
   localparam int STATUS_W    = 2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FEW      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [SAMPLE_W-1:0] SD_MAX = '1;

endpackage

/* rtl/smsd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample mean and standard deviation channels
// Valid/ready channels for the sample requests and the result requests.
// ----------------------------------------------------------------------------
interface smsd_req_if
   import smsd_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface smsd_rsp_if
   import smsd_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean_value;
   logic        [SAMPLE_W-1:0] std_dev;
   logic        [STATUS_W-1:0] status;

   modport source (output valid, output mean_value, output std_dev, output status,
                   input ready);
   modport sink (input valid, input mean_value, input std_dev, input status,
                 output ready);
endinterface

/* rtl/smsd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smsd_div
   import smsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SQ_W-1:0]  dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic [SQ_W-1:0]  quotient,
   output logic             done
);

   localparam int STEP_W = $clog2(SQ_W);

   logic [SQ_W-1:0]   quo_ff;
   logic [SQ_W-1:0]   quo_in;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W-1:0]  rem_in;
   logic [CNT_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W:0]    trial;
   logic              fits;

   assign trial  = {rem_ff, quo_ff[SQ_W-1]};
   assign fits   = (trial >= {1'b0, dvs_ff});
   assign rem_in = fits ? CNT_W'(trial - {1'b0, dvs_ff}) : trial[CNT_W-1:0];
   assign quo_in = {quo_ff[SQ_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

/* rtl/smsd_sqacc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial square accumulator
// Squares a deviation by shift and add, one bit per cycle, and adds it up.
// ----------------------------------------------------------------------------
module smsd_sqacc
   import smsd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] mag,
   output logic [SQ_W-1:0]     acc,
   output logic                done
);

   localparam int STEP_W = $clog2(SAMPLE_W);

   logic [SAMPLE_W-1:0]   mcand_ff;
   logic [2*SAMPLE_W-1:0] prod_ff;
   logic [2*SAMPLE_W-1:0] prod_in;
   logic [SAMPLE_W:0]     partial;
   logic [STEP_W-1:0]     step_ff;
   logic                  busy_ff;
   logic                  add_ff;
   logic                  done_ff;
   logic [SQ_W-1:0]       acc_ff;

   assign partial = {1'b0, prod_ff[2*SAMPLE_W-1:SAMPLE_W]}
                  + {1'b0, (prod_ff[0] ? mcand_ff : {SAMPLE_W{1'b0}})};
   assign prod_in = {partial, prod_ff[SAMPLE_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         add_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
         acc_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (clear) begin
            acc_ff <= '0;
         end
         if (start) begin
            mcand_ff <= mag;
            prod_ff  <= {{SAMPLE_W{1'b0}}, mag};
            step_ff  <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            prod_ff <= prod_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(SAMPLE_W - 1)) begin
               busy_ff <= 1'b0;
               add_ff  <= 1'b1;
            end
         end
         if (add_ff) begin
            acc_ff  <= acc_ff + SQ_W'(prod_ff);
            add_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

/* rtl/smsd_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial square root
// Floor integer square root, two radicand bits and one root bit per cycle.
// ----------------------------------------------------------------------------
module smsd_sqrt
   import smsd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   radicand,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   localparam int RAD_W  = 2 * ROOT_W;
   localparam int STEP_W = $clog2(ROOT_W);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] subtrahend;
   logic [ROOT_W+2:0] diff;
   logic              fits;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;

   assign trial      = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign subtrahend = {1'b0, root_ff, 2'b01};
   assign fits       = (trial >= subtrahend);
   assign diff       = trial - subtrahend;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rad_ff  <= RAD_W'(radicand);
            root_ff <= '0;
            rem_ff  <= '0;
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
            root_ff <= {root_ff[ROOT_W-2:0], fits};
            rem_ff  <= fits ? diff[ROOT_W:0] : trial[ROOT_W:0];
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

/* rtl/sample_mean_and_std_dev.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample mean and standard deviation
// Two-pass mean and sample standard deviation over a set of Q8.8 samples.
// ----------------------------------------------------------------------------
// The request channel carries one signed Q8.8 sample per request, with
// last_sample marking the end of a set. Samples are taken one per cycle and
// written to an internal store while a running sum is kept. A full store
// drops further samples and flags an overflow.
// After the marked sample the block stops taking requests while it works:
// the mean is found by a serial divider, each stored sample is read back
// and its squared deviation is formed by a bit-serial squarer, the sum is
// divided by the count less one and a serial square root follows. A set
// that is too small or overflowed skips these steps and goes straight to
// its result request.
// The result request carries mean_value, std_dev and status and sits in an
// output register; new samples are taken while it waits. If a further result
// is ready before the receiver takes the previous one, the block holds it
// and takes no requests until the output register frees up.
// Reset empties the set and the output register; the store needs no clearing.
// ----------------------------------------------------------------------------
module sample_mean_and_std_dev
   import smsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   smsd_req_if.sink   req_ch,
   smsd_rsp_if.source rsp_ch
);

   typedef enum logic [3:0] {
      S_LOAD,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_READ,
      S_SQ_GO,
      S_SQ_WAIT,
      S_VAR_GO,
      S_VAR_WAIT,
      S_ROOT_GO,
      S_ROOT_WAIT,
      S_EMIT
   } state_type;

   state_type                  state_ff;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic [CNT_W-1:0]           idx_ff;
   logic [CNT_W-1:0]           idx_in;
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic                       overflow_ff;
   logic                       overflow_in;
   logic                       has_room;
   logic                       req_take;

   logic [SAMPLE_W-1:0]        mem [MAX_SAMPLES];
   logic [SAMPLE_W-1:0]        rd_ff;

   logic [SAMPLE_W-1:0]        mean_ff;
   logic [SAMPLE_W-1:0]        sd_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic                       rsp_valid_ff;
   logic [SAMPLE_W-1:0]        rsp_mean_ff;
   logic [SAMPLE_W-1:0]        rsp_sd_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;

   logic [SUM_W-1:0]           sum_mag;
   logic                       div_start;
   logic [SQ_W-1:0]            div_dividend;
   logic [CNT_W-1:0]           div_divisor;
   logic [SQ_W-1:0]            div_quot;
   logic                       div_done;
   logic [SAMPLE_W-1:0]        mean_q;
   logic [SAMPLE_W-1:0]        mean_res;

   logic [SAMPLE_W:0]          diff;
   logic [SAMPLE_W:0]          diff_abs;
   logic                       acc_clear;
   logic                       sq_start;
   logic [SQ_W-1:0]            sq_sum;
   logic                       sq_done;

   logic                       rt_start;
   logic [ROOT_W-1:0]          rt_root;
   logic                       rt_done;
   logic [SAMPLE_W-1:0]        sd_res;

   assign req_ch.ready = (state_ff == S_LOAD);
   assign req_take     = req_ch.valid && req_ch.ready;

   assign has_room    = (count_ff < CNT_W'(MAX_SAMPLES));
   assign count_in    = has_room ? count_ff + 1'b1 : count_ff;
   assign sum_in      = has_room
                      ? sum_ff + {{(SUM_W-SAMPLE_W){req_ch.sample[SAMPLE_W-1]}}, req_ch.sample}
                      : sum_ff;
   assign overflow_in = overflow_ff || !has_room;
   assign idx_in      = idx_ff + 1'b1;

   assign sum_mag      = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign div_start    = (state_ff == S_MEAN_GO) || (state_ff == S_VAR_GO);
   assign div_dividend = (state_ff == S_MEAN_GO) ? SQ_W'(sum_mag) : sq_sum;
   assign div_divisor  = (state_ff == S_MEAN_GO) ? count_ff : count_ff - 1'b1;
   assign mean_q       = div_quot[SAMPLE_W-1:0];
   assign mean_res     = sum_ff[SUM_W-1] ? SAMPLE_W'(-mean_q) : mean_q;

   assign diff      = {rd_ff[SAMPLE_W-1], rd_ff} - {mean_ff[SAMPLE_W-1], mean_ff};
   assign diff_abs  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
   assign acc_clear = (state_ff == S_MEAN_GO);
   assign sq_start  = (state_ff == S_SQ_GO);

   assign rt_start = (state_ff == S_ROOT_GO);
   assign sd_res   = (|rt_root[ROOT_W-1:SAMPLE_W]) ? SD_MAX : rt_root[SAMPLE_W-1:0];

   smsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   smsd_sqacc u_sqacc (
      .clock (clock),
      .reset (reset),
      .clear (acc_clear),
      .start (sq_start),
      .mag   (diff_abs[SAMPLE_W-1:0]),
      .acc   (sq_sum),
      .done  (sq_done)
   );

   smsd_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (div_quot),
      .root     (rt_root),
      .done     (rt_done)
   );

   always_ff @(posedge clock) begin
      if (req_take && has_room) begin
         mem[count_ff[ADDR_W-1:0]] <= req_ch.sample;
      end
      rd_ff <= mem[idx_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         sum_ff       <= '0;
         overflow_ff  <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (req_take) begin
                  count_ff    <= count_in;
                  sum_ff      <= sum_in;
                  overflow_ff <= overflow_in;
                  if (req_ch.last_sample) begin
                     priority if (overflow_in) begin
                        mean_ff   <= '0;
                        sd_ff     <= '0;
                        status_ff <= STATUS_OVERFLOW;
                        state_ff  <= S_EMIT;
                     end else if (count_in < CNT_W'(2)) begin
                        mean_ff   <= '0;
                        sd_ff     <= '0;
                        status_ff <= STATUS_FEW;
                        state_ff  <= S_EMIT;
                     end else begin
                        state_ff <= S_MEAN_GO;
                     end
                  end
               end
            end
            S_MEAN_GO: begin
               state_ff <= S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
               if (div_done) begin
                  mean_ff  <= mean_res;
                  idx_ff   <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_SQ_GO;
            end
            S_SQ_GO: begin
               state_ff <= S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
               if (sq_done) begin
                  idx_ff <= idx_in;
                  if (idx_in == count_ff) begin
                     state_ff <= S_VAR_GO;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_VAR_GO: begin
               state_ff <= S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
               if (div_done) begin
                  state_ff <= S_ROOT_GO;
               end
            end
            S_ROOT_GO: begin
               state_ff <= S_ROOT_WAIT;
            end
            S_ROOT_WAIT: begin
               if (rt_done) begin
                  sd_ff     <= sd_res;
                  status_ff <= STATUS_OK;
                  state_ff  <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_mean_ff   <= mean_ff;
                  rsp_sd_ff     <= sd_ff;
                  rsp_status_ff <= status_ff;
                  count_ff      <= '0;
                  sum_ff        <= '0;
                  overflow_ff   <= 1'b0;
                  state_ff      <= S_LOAD;
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.mean_value = rsp_mean_ff;
   assign rsp_ch.std_dev    = rsp_sd_ff;
   assign rsp_ch.status     = rsp_status_ff;

`ifndef SYNTHESIS
   a_last_leaves_load: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.last_sample) |=> (state_ff != S_LOAD))
      else $error("Marked sample did not end the loading phase.");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("Result request raised outside the emit state.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK))
         |-> ((rsp_mean_ff == '0) && (rsp_sd_ff == '0)))
      else $error("Error result carries nonzero values.");

   a_pass_index: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_READ) || (state_ff == S_SQ_GO) || (state_ff == S_SQ_WAIT))
         |-> (idx_ff < count_ff))
      else $error("Second pass index ran past the sample count.");
`endif

endmodule

/* sim/tb_sample_mean_and_std_dev.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample mean and standard deviation testbench
// Feeds sets of signed Q8.8 samples through the request channel, starting
// with a short table of hand-picked sets and going on with random sets of
// varied size and spread. Each set ends in one result request. A model of the
// two-pass mean and standard deviation predicts every result but for the table
// sets that give their own, and the result channel is compared with the expected
// result field by field. Both sides idle at random, the receiver holds off once
// for a long stretch, and the sender once waits for every outstanding result.
// ----------------------------------------------------------------------------
module tb_sample_mean_and_std_dev;
   import smsd_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int RANDOM_ITEMS = 1426;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;
   localparam int LONG_HOLD    = 800;
   localparam int HOLD_AT      = 30;
   localparam int FULL_SET_NO  = 12;
   localparam int OVER_SET_NO  = 25;
   localparam int PAUSE_SET_NO = 40;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean;
      logic        [SAMPLE_W-1:0] sd;
      logic        [STATUS_W-1:0] status;
   } stats_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
      logic                       typed;
      stats_type                  want;
   } set_row_type;

   localparam stats_type NO_WANT = '0;

   localparam set_row_type SET_TABLE [0:23] = '{
      '{16'sh1234, 1'b1, 1'b1, '{16'sh0000, 16'h0000, STATUS_FEW}},
      '{16'sh8000, 1'b1, 1'b1, '{16'sh0000, 16'h0000, STATUS_FEW}},
      '{16'sh7FFF, 1'b0, 1'b0, NO_WANT},
      '{16'sh7FFF, 1'b1, 1'b1, '{16'sh7FFF, 16'h0000, STATUS_OK}},
      '{16'sh8000, 1'b0, 1'b0, NO_WANT},
      '{16'sh8000, 1'b1, 1'b1, '{16'sh8000, 16'h0000, STATUS_OK}},
      '{16'sh8000, 1'b0, 1'b0, NO_WANT},
      '{16'sh7FFF, 1'b1, 1'b0, NO_WANT},
      '{16'shFFFD, 1'b0, 1'b0, NO_WANT},
      '{16'sh0000, 1'b1, 1'b0, NO_WANT},
      '{16'sh0000, 1'b0, 1'b0, NO_WANT},
      '{16'sh0000, 1'b0, 1'b0, NO_WANT},
      '{16'sh0000, 1'b1, 1'b1, '{16'sh0000, 16'h0000, STATUS_OK}},
      '{16'sh0100, 1'b0, 1'b0, NO_WANT},
      '{16'sh0200, 1'b0, 1'b0, NO_WANT},
      '{16'sh0300, 1'b1, 1'b0, NO_WANT},
      '{16'sh0064, 1'b0, 1'b0, NO_WANT},
      '{16'shFF9C, 1'b0, 1'b0, NO_WANT},
      '{16'sh0064, 1'b0, 1'b0, NO_WANT},
      '{16'shFF9C, 1'b0, 1'b0, NO_WANT},
      '{16'sh0064, 1'b1, 1'b0, NO_WANT},
      '{16'shFFFF, 1'b0, 1'b0, NO_WANT},
      '{16'sh5555, 1'b0, 1'b0, NO_WANT},
      '{16'shAAAA, 1'b1, 1'b0, NO_WANT}
   };

   logic clock;
   logic reset;

   smsd_req_if req_ch ();
   smsd_rsp_if rsp_ch ();

   sample_mean_and_std_dev dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic signed [SAMPLE_W-1:0] held_samples [MAX_SAMPLES];
   int unsigned                held_count;
   longint                     set_sum;
   logic                       set_overflow;

   stats_type pending_results [$];
   int        mismatch_count = 0;
   int        results_seen;
   int        cycle_count = 0;
   int        sender_calm;
   int        receiver_calm;

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0)
         calm_left = $urandom_range(10, 40);
      return $urandom_range(0, 9);
   endfunction

   // Stores one sample of the current set; on the last one, forms the
   // result and clears the set.
   function automatic logic predict_stats(input logic signed [SAMPLE_W-1:0] s,
                                          input logic last, output stats_type r);
      longint          mean;
      longint          dev;
      longint unsigned sq_acc;
      longint unsigned var_q;
      longint unsigned root;
      longint unsigned trial;
      r = '0;
      if (held_count < MAX_SAMPLES) begin
         held_samples[held_count] = s;
         held_count++;
         set_sum += s;
      end else begin
         set_overflow = 1'b1;
      end
      if (!last)
         return 1'b0;
      if (set_overflow) begin
         r.status = STATUS_OVERFLOW;
      end else if (held_count < 2) begin
         r.status = STATUS_FEW;
      end else begin
         mean   = set_sum / longint'(held_count);
         sq_acc = 0;
         for (int i = 0; i < held_count; i++) begin
            dev = longint'(held_samples[i]) - mean;
            sq_acc += dev * dev;
         end
         var_q = sq_acc / (held_count - 1);
         root  = 0;
         for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= var_q)
               root = trial;
         end
         r.mean   = mean[SAMPLE_W-1:0];
         r.sd     = (root > SD_MAX) ? SD_MAX : root[SAMPLE_W-1:0];
         r.status = STATUS_OK;
      end
      held_count   = 0;
      set_sum      = 0;
      set_overflow = 1'b0;
      return 1'b1;
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last,
                              input logic typed, input stats_type want);
      int        gap;
      stats_type predicted;
      gap = draw_gap(sender_calm);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.sample      <= s;
      req_ch.last_sample <= last;
      do @(posedge clock); while (!req_ch.ready);
      if (predict_stats(s, last, predicted))
         pending_results.push_back(typed ? want : predicted);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      int                         items_sent;
      int                         set_no;
      int                         set_size;
      int                         value_mode;
      logic signed [SAMPLE_W-1:0] base;
      logic        [SAMPLE_W-1:0] spread_mask;
      logic signed [SAMPLE_W-1:0] value;
      req_ch.valid       = 1'b0;
      req_ch.sample      = '0;
      req_ch.last_sample = 1'b0;
      reset              = 1'b1;
      held_count         = 0;
      set_sum            = 0;
      set_overflow       = 1'b0;
      sender_calm        = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (SET_TABLE[i])
         send_sample(SET_TABLE[i].sample, SET_TABLE[i].last, SET_TABLE[i].typed,
                     SET_TABLE[i].want);

      items_sent = 0;
      set_no     = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (set_no == FULL_SET_NO)
            set_size = MAX_SAMPLES;
         else if (set_no == OVER_SET_NO)
            set_size = MAX_SAMPLES + 1 + $urandom_range(0, 3);
         else if ($urandom_range(0, 99) < 8)
            set_size = 1;
         else if ($urandom_range(0, 99) < 6)
            set_size = $urandom_range(20, 60);
         else
            set_size = $urandom_range(2, 10);
         if (set_no == PAUSE_SET_NO)
            wait_for_results();
         value_mode  = $urandom_range(0, 2);
         base        = SAMPLE_W'($urandom);
         spread_mask = (16'd1 << $urandom_range(0, 15)) - 16'd1;
         for (int k = 0; k < set_size; k++) begin
            case (value_mode)
               0: value = SAMPLE_W'($urandom);
               1: value = base + SAMPLE_W'($urandom & spread_mask);
               default: begin
                  if ($urandom_range(0, 3) == 0)
                     value = SAMPLE_W'($urandom);
                  else
                     value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               end
            endcase
            send_sample(value, k == set_size - 1, 1'b0, NO_WANT);
         end
         items_sent += set_size;
         set_no++;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      int        gap;
      logic      held_off;
      stats_type expected;
      rsp_ch.ready  = 1'b0;
      results_seen  = 0;
      receiver_calm = 0;
      held_off      = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap(receiver_calm);
         if (!held_off && results_seen == HOLD_AT) begin
            gap      = LONG_HOLD;
            held_off = 1'b1;
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         results_seen++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result request mean_value %0d std_dev %0d status %0d",
                     $time, rsp_ch.mean_value, rsp_ch.std_dev, rsp_ch.status);
            mismatch_count++;
         end else begin
            expected = pending_results.pop_front();
            if (rsp_ch.mean_value !== expected.mean) begin
               $display("%0t: mean_value expected %0d, got %0d", $time, expected.mean,
                        rsp_ch.mean_value);
               mismatch_count++;
            end
            if (rsp_ch.std_dev !== expected.sd) begin
               $display("%0t: std_dev expected %0d, got %0d", $time, expected.sd,
                        rsp_ch.std_dev);
               mismatch_count++;
            end
            if (rsp_ch.status !== expected.status) begin
               $display("%0t: status expected %0d, got %0d", $time, expected.status,
                        rsp_ch.status);
               mismatch_count++;
            end
         end
         @(negedge clock);
      end
   end

endmodule

/* files.f */
rtl/smsd_pkg.sv
rtl/smsd_if.sv
rtl/smsd_div.sv
rtl/smsd_sqacc.sv
rtl/smsd_sqrt.sv
rtl/sample_mean_and_std_dev.sv
sim/tb_sample_mean_and_std_dev.sv
